/* rtl/see_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// see_pkg
// Shared constants of the stack expression evaluator.
// ---------------------------------------------------------------------------
package see_pkg;
    localparam int STACK_ENTRIES = 32;
    localparam int SP_W  = $clog2(STACK_ENTRIES);
    localparam int CNT_W = $clog2(STACK_ENTRIES + 1);

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_MALFORMED   = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    localparam logic [7:0] OP_END  = 8'h00;
    localparam logic [7:0] OP_PUSH = 8'h01;
    localparam logic [7:0] OP_FLD  = 8'h02;
    localparam logic [7:0] OP_REM  = 8'h03;
    localparam logic [7:0] OP_SIZE = 8'h04;
    localparam logic [7:0] OP_ARGF = 8'h07;
    localparam logic [7:0] OP_ADD  = 8'h10;
    localparam logic [7:0] OP_SUB  = 8'h11;
    localparam logic [7:0] OP_MUL  = 8'h12;
    localparam logic [7:0] OP_DIV  = 8'h13;
    localparam logic [7:0] OP_MOD  = 8'h14;
    localparam logic [7:0] OP_AND  = 8'h15;
    localparam logic [7:0] OP_OR   = 8'h16;
    localparam logic [7:0] OP_XOR  = 8'h17;
    localparam logic [7:0] OP_SHL  = 8'h18;
    localparam logic [7:0] OP_SHR  = 8'h19;
    localparam logic [7:0] OP_NEG  = 8'h1a;
    localparam logic [7:0] OP_NOT  = 8'h1b;
    localparam logic [7:0] OP_EQ   = 8'h20;
    localparam logic [7:0] OP_NE   = 8'h21;
    localparam logic [7:0] OP_LT   = 8'h22;
    localparam logic [7:0] OP_LE   = 8'h23;
    localparam logic [7:0] OP_GT   = 8'h24;
    localparam logic [7:0] OP_GE   = 8'h25;
    localparam logic [7:0] OP_LAND = 8'h26;
    localparam logic [7:0] OP_LOR  = 8'h27;
    localparam logic [7:0] OP_MIN  = 8'h30;
    localparam logic [7:0] OP_MAX  = 8'h31;
    localparam logic [7:0] OP_ALGN = 8'h32;
endpackage
`default_nettype wire

/* rtl/see_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// see_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module see_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/stack_expression_evaluator.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// stack_expression_evaluator
// Postfix evaluator over a 64-bit operand stack held in RAM.
// ---------------------------------------------------------------------------
// channel | dir | payload
// s_      | in  | tdata {operand, mode}, tuser {truncated, load_status}, tlast
// m_      | out | tdata {value}, tuser {status}
//
// Push, unary, end and early errors are handled in S_IDLE. Binary ops pass through
// accept, RAM read of the second entry, execute and commit.
// Multiply adds S_MUL1: three 32x32 partial products, registered, then summed.
// Div/mod use a 64-step radix-2 divider; align-up divides, then multiplies.
// Stack top is kept in a register, only the rest in RAM.
// Synchronous active-low reset clears depth, finished flag, output valid and state.
// A result waits in the output register; input is held off until it is taken.
module stack_expression_evaluator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [7:0] mode, [71:8] operand
    input  wire logic [2:0]  s_tuser,   // [1:0] load_status, [2] truncated
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] value
    output logic [1:0]       m_tuser    // [1:0] status
);
    import see_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EXEC, S_MUL1, S_MUL2, S_DIV, S_DFIN, S_AMUL1, S_AMUL2, S_OUT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  depth_reg;
    logic              fin_reg;
    logic [63:0]       top_reg;      // top of stack; RAM holds entries below
    logic [7:0]        op_reg;
    logic              last_reg;
    logic [63:0]       l_reg, r_reg, acc_reg;
    logic [63:0]       pp_reg [3];
    logic [63:0]       dq_reg, drem_reg, dd_reg;
    logic [6:0]        dcnt_reg;
    logic              m_valid_reg;
    logic [63:0]       m_data_reg;
    logic [1:0]        m_user_reg;

    // RAM entry i holds stack element i below the top; the top lives only in top_reg
    logic              ram_we;
    logic [SP_W-1:0]   ram_waddr, ram_raddr;
    logic [63:0]       ram_wdata, ram_rdata;

    see_ram #(.WIDTH(64), .DEPTH(STACK_ENTRIES)) u_stack (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [7:0]  in_mode;
    logic [63:0] in_opnd;
    logic [1:0]  in_ls;
    logic        in_tr;
    assign in_mode = s_tdata[7:0];
    assign in_opnd = s_tdata[71:8];
    assign in_ls   = s_tuser[1:0];
    assign in_tr   = s_tuser[2];

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    logic acc;
    assign acc = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    logic is_bin;
    always_comb begin
        case (in_mode)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
            OP_SHL, OP_SHR, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE,
            OP_LAND, OP_LOR, OP_MIN, OP_MAX, OP_ALGN: is_bin = 1'b1;
            default: is_bin = 1'b0;
        endcase
    end

    // ALU on registered operands
    logic [63:0] alu;
    logic        alu_bad;
    logic [5:0]  sh;
    always_comb begin
        sh = r_reg[5:0];
        alu_bad = 1'b0;
        case (op_reg)
            OP_ADD:  alu = l_reg + r_reg;
            OP_SUB:  alu = l_reg - r_reg;
            OP_MUL:  alu = '0;
            OP_AND:  alu = l_reg & r_reg;
            OP_OR:   alu = l_reg | r_reg;
            OP_XOR:  alu = l_reg ^ r_reg;
            OP_SHL:  alu = (r_reg[63:6] == '0) ? (l_reg << sh) : '0;
            OP_SHR:  alu = (r_reg[63:6] == '0) ? 64'($signed(l_reg) >>> sh) : '0;
            OP_EQ:   alu = {63'd0, l_reg == r_reg};
            OP_NE:   alu = {63'd0, l_reg != r_reg};
            OP_LT:   alu = {63'd0, slt(l_reg, r_reg)};
            OP_LE:   alu = {63'd0, !slt(r_reg, l_reg)};
            OP_GT:   alu = {63'd0, slt(r_reg, l_reg)};
            OP_GE:   alu = {63'd0, !slt(l_reg, r_reg)};
            OP_LAND: alu = {63'd0, (l_reg != '0) && (r_reg != '0)};
            OP_LOR:  alu = {63'd0, (l_reg != '0) || (r_reg != '0)};
            OP_MIN:  alu = slt(l_reg, r_reg) ? l_reg : r_reg;
            OP_MAX:  alu = slt(r_reg, l_reg) ? l_reg : r_reg;
            OP_DIV, OP_MOD: begin
                alu = '0;
                alu_bad = (r_reg == '0);
            end
            OP_ALGN: begin
                alu = '0;
                alu_bad = (r_reg == '0) || r_reg[63];
            end
            default: begin
                alu = '0;
                alu_bad = 1'b1;
            end
        endcase
    end

    // divider step: unsigned magnitudes
    logic [64:0] dtrial;
    logic [63:0] drem_sh;
    assign drem_sh = {drem_reg[62:0], dq_reg[63]};
    assign dtrial  = {1'b0, drem_sh} - {1'b0, dd_reg};

    logic [63:0] a_mag, b_mag;
    assign a_mag = l_reg[63] ? (64'd0 - l_reg) : l_reg;
    assign b_mag = r_reg[63] ? (64'd0 - r_reg) : r_reg;

    logic [63:0] mul_sum;
    assign mul_sum = pp_reg[0] + {pp_reg[1][31:0], 32'd0} + {pp_reg[2][31:0], 32'd0};

    // RAM access control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = depth_reg[SP_W-1:0] - SP_W'(1);
        ram_wdata = top_reg;
        ram_raddr = depth_reg[SP_W-1:0] - SP_W'(2);
        // push: spill old top to its slot (depth-1)
        if (acc && !fin_reg && (in_mode == OP_PUSH || in_mode == OP_FLD ||
                                in_mode == OP_REM) && depth_reg != '0) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        op_reg   <= in_mode;
                        last_reg <= s_tlast;
                        if (fin_reg) begin
                            if (s_tlast) begin
                                fin_reg   <= 1'b0;
                                depth_reg <= '0;
                            end
                        end else if (in_mode == OP_END) begin
                            m_valid_reg <= 1'b1;
                            m_user_reg  <= (depth_reg == CNT_W'(1)) ? ST_OK : ST_MALFORMED;
                            m_data_reg  <= (depth_reg == CNT_W'(1)) ? top_reg : '0;
                            fin_reg     <= !s_tlast;
                            if (s_tlast) depth_reg <= '0;
                        end else if (in_mode == OP_PUSH || in_mode == OP_FLD ||
                                     in_mode == OP_REM) begin
                            if ((in_mode != OP_REM && in_tr) ||
                                depth_reg == CNT_W'(STACK_ENTRIES)) begin
                                m_valid_reg <= 1'b1;
                                m_user_reg  <= ST_MALFORMED;
                                m_data_reg  <= '0;
                                fin_reg     <= !s_tlast;
                                if (s_tlast) depth_reg <= '0;
                            end else if (in_mode == OP_FLD && in_ls != ST_OK) begin
                                m_valid_reg <= 1'b1;
                                m_user_reg  <= in_ls;
                                m_data_reg  <= '0;
                                fin_reg     <= !s_tlast;
                                if (s_tlast) depth_reg <= '0;
                            end else if (s_tlast) begin
                                m_valid_reg <= 1'b1;
                                m_user_reg  <= ST_MALFORMED;
                                m_data_reg  <= '0;
                                depth_reg   <= '0;
                            end else begin
                                top_reg   <= in_opnd;
                                depth_reg <= depth_reg + CNT_W'(1);
                            end
                        end else if (in_mode >= OP_SIZE && in_mode <= OP_ARGF) begin
                            m_valid_reg <= 1'b1;
                            m_user_reg  <= ST_UNSUPPORTED;
                            m_data_reg  <= '0;
                            fin_reg     <= !s_tlast;
                            if (s_tlast) depth_reg <= '0;
                        end else if (in_mode == OP_NEG || in_mode == OP_NOT) begin
                            if (depth_reg == '0 || s_tlast) begin
                                m_valid_reg <= 1'b1;
                                m_user_reg  <= ST_MALFORMED;
                                m_data_reg  <= '0;
                                fin_reg     <= !s_tlast;
                                if (s_tlast) depth_reg <= '0;
                            end else begin
                                top_reg <= (in_mode == OP_NEG) ? (64'd0 - top_reg) : ~top_reg;
                            end
                        end else if (depth_reg < CNT_W'(2)) begin
                            m_valid_reg <= 1'b1;
                            m_user_reg  <= ST_MALFORMED;
                            m_data_reg  <= '0;
                            fin_reg     <= !s_tlast;
                            if (s_tlast) depth_reg <= '0;
                        end else if (!is_bin) begin
                            m_valid_reg <= 1'b1;
                            m_user_reg  <= ST_UNSUPPORTED;
                            m_data_reg  <= '0;
                            fin_reg     <= !s_tlast;
                            if (s_tlast) depth_reg <= '0;
                        end else begin
                            r_reg     <= top_reg;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    // RAM output valid now: second entry
                    l_reg     <= ram_rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    if (alu_bad) begin
                        acc_reg   <= '0;
                        state_reg <= S_OUT;
                        m_user_reg <= ST_MALFORMED;
                    end else if (op_reg == OP_MUL) begin
                        pp_reg[0] <= l_reg[31:0] * r_reg[31:0];
                        pp_reg[1] <= l_reg[63:32] * r_reg[31:0];
                        pp_reg[2] <= l_reg[31:0] * r_reg[63:32];
                        state_reg <= S_MUL1;
                    end else if (op_reg == OP_DIV || op_reg == OP_MOD ||
                                 op_reg == OP_ALGN) begin
                        if (op_reg == OP_ALGN) begin
                            l_reg <= l_reg + r_reg - 64'd1;
                            state_reg <= S_MUL2;   // let the new dividend settle in l_reg first
                        end else begin
                            dq_reg    <= a_mag;
                            dd_reg    <= b_mag;
                            drem_reg  <= '0;
                            dcnt_reg  <= '0;
                            state_reg <= S_DIV;
                        end
                    end else begin
                        acc_reg    <= alu;
                        m_user_reg <= ST_OK;
                        state_reg  <= S_OUT;
                    end
                end
                S_MUL1: begin
                    acc_reg    <= mul_sum;
                    m_user_reg <= ST_OK;
                    state_reg  <= S_OUT;
                end
                S_MUL2: begin
                    dq_reg    <= a_mag;
                    dd_reg    <= b_mag;
                    drem_reg  <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (!dtrial[64]) begin
                        drem_reg <= dtrial[63:0];
                        dq_reg   <= {dq_reg[62:0], 1'b1};
                    end else begin
                        drem_reg <= drem_sh;
                        dq_reg   <= {dq_reg[62:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 7'd1;
                    if (dcnt_reg == 7'd63) state_reg <= S_DFIN;
                end
                S_DFIN: begin
                    m_user_reg <= ST_OK;
                    if (op_reg == OP_MOD) begin
                        acc_reg   <= l_reg[63] ? (64'd0 - drem_reg) : drem_reg;
                        state_reg <= S_OUT;
                    end else if (op_reg == OP_DIV) begin
                        acc_reg   <= (l_reg[63] ^ r_reg[63]) ? (64'd0 - dq_reg) : dq_reg;
                        state_reg <= S_OUT;
                    end else begin
                        // align: quotient times divisor
                        l_reg     <= (l_reg[63] ^ r_reg[63]) ? (64'd0 - dq_reg) : dq_reg;
                        state_reg <= S_AMUL1;
                    end
                end
                S_AMUL1: begin
                    pp_reg[0] <= l_reg[31:0] * r_reg[31:0];
                    pp_reg[1] <= l_reg[63:32] * r_reg[31:0];
                    pp_reg[2] <= l_reg[31:0] * r_reg[63:32];
                    state_reg <= S_AMUL2;
                end
                S_AMUL2: begin
                    acc_reg   <= mul_sum;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // commit: pop one, replace top, or report error
                    if (m_user_reg != ST_OK) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '0;
                        fin_reg     <= !last_reg;
                        if (last_reg) depth_reg <= '0;
                    end else if (last_reg) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= ST_MALFORMED;
                        m_data_reg  <= '0;
                        depth_reg   <= '0;
                    end else begin
                        top_reg   <= acc_reg;
                        depth_reg <= depth_reg - CNT_W'(1);
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* verif/tb_stack_expression_evaluator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stack_expression_evaluator
// Drives random and directed bytecode programs into the evaluator. Each
// program is modeled in the testbench and every result is checked in order.
// ---------------------------------------------------------------------------
module tb_stack_expression_evaluator;
    import see_pkg::*;

    localparam int WATCHDOG = 20000;

    class eval_scoreboard;
        logic [63:0] stk [STACK_ENTRIES];
        int          depth;
        bit          done;
        logic [1:0]  exp_status [$];
        logic [63:0] exp_value [$];
        int          mismatches;
        int          results;

        function new();
            depth = 0;
            done = 0;
            mismatches = 0;
            results = 0;
        endfunction

        static function logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
            logic [63:0] ma, mb, q;
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            q = ma / mb;
            return (a[63] ^ b[63]) ? -q : q;
        endfunction

        static function logic [63:0] smod(logic [63:0] a, logic [63:0] b);
            logic [63:0] ma, mb, r;
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            r = ma % mb;
            return a[63] ? -r : r;
        endfunction

        // returns 1 when the instruction ends the evaluation
        function bit execute(logic [7:0] op, logic [63:0] opnd, logic [1:0] ls,
                             bit trunc, output logic [1:0] st,
                             output logic [63:0] val);
            logic [63:0] l, r, a;
            val = '0;
            st = ST_MALFORMED;
            if (op == OP_END) begin
                if (depth != 1) return 1;
                st = ST_OK;
                val = stk[0];
                return 1;
            end
            if (op == OP_PUSH || op == OP_FLD || op == OP_REM) begin
                if (depth >= STACK_ENTRIES) return 1;
                if (op != OP_REM && trunc) return 1;
                if (op == OP_FLD && ls != 0) begin
                    st = ls;
                    return 1;
                end
                stk[depth] = opnd;
                depth++;
                return 0;
            end
            if (op >= OP_SIZE && op <= OP_ARGF) begin
                st = ST_UNSUPPORTED;
                return 1;
            end
            if (op == OP_NEG || op == OP_NOT) begin
                if (depth < 1) return 1;
                stk[depth-1] = (op == OP_NEG) ? -stk[depth-1] : ~stk[depth-1];
                return 0;
            end
            if (depth < 2) return 1;
            r = stk[depth-1];
            l = stk[depth-2];
            case (op)
                OP_ADD:  a = l + r;
                OP_SUB:  a = l - r;
                OP_MUL:  a = l * r;
                OP_DIV: begin
                    if (r == 0) return 1;
                    a = sdiv(l, r);
                end
                OP_MOD: begin
                    if (r == 0) return 1;
                    a = smod(l, r);
                end
                OP_AND:  a = l & r;
                OP_OR:   a = l | r;
                OP_XOR:  a = l ^ r;
                OP_SHL:  a = (r < 64) ? l << r[5:0] : '0;
                OP_SHR:  a = (r < 64) ? 64'($signed(l) >>> r[5:0]) : '0;
                OP_EQ:   a = 64'(l == r);
                OP_NE:   a = 64'(l != r);
                OP_LT:   a = 64'($signed(l) < $signed(r));
                OP_LE:   a = 64'($signed(l) <= $signed(r));
                OP_GT:   a = 64'($signed(l) > $signed(r));
                OP_GE:   a = 64'($signed(l) >= $signed(r));
                OP_LAND: a = 64'(l != 0 && r != 0);
                OP_LOR:  a = 64'(l != 0 || r != 0);
                OP_MIN:  a = ($signed(l) < $signed(r)) ? l : r;
                OP_MAX:  a = ($signed(r) < $signed(l)) ? l : r;
                OP_ALGN: begin
                    if (r == 0 || r[63]) return 1;
                    a = sdiv(l + r - 1, r) * r;
                end
                default: begin
                    st = ST_UNSUPPORTED;
                    return 1;
                end
            endcase
            depth--;
            stk[depth-1] = a;
            return 0;
        endfunction

        function void note_input(logic [7:0] op, logic [63:0] opnd, logic [1:0] ls,
                                 bit trunc, bit last);
            logic [1:0]  st;
            logic [63:0] val;
            bit          fin;
            if (!done) begin
                fin = execute(op, opnd, ls, trunc, st, val);
                if (!fin && last) begin
                    fin = 1;
                    st = ST_MALFORMED;
                    val = '0;
                end
                if (fin) begin
                    exp_status.push_back(st);
                    exp_value.push_back(val);
                    done = 1;
                end
            end
            if (last) begin
                depth = 0;
                done = 0;
            end
        endfunction

        function void check_result(logic [1:0] st, logic [63:0] val);
            logic [1:0]  es;
            logic [63:0] ev;
            results++;
            if (exp_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d value=%h", st, val);
                return;
            end
            es = exp_status.pop_front();
            ev = exp_value.pop_front();
            if (st !== es || val !== ev) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d exp status=%0d value=%h got status=%0d value=%h",
                             results, es, ev, st, val);
            end
        endfunction

        function int pending();
            return exp_status.size();
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    eval_scoreboard sb = new();
    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    int  idle_cycles = 0;
    int  items_sent = 0;
    bit  timed_out = 0;

    always #10 aclk = ~aclk;

    stack_expression_evaluator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata[7:0], s_tdata[71:8], s_tuser[1:0],
                              s_tuser[2], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // tvalid stays high after the handshake until the next item or idle cycle
    task automatic send_item(logic [7:0] op, logic [63:0] opnd, logic [1:0] ls,
                             bit trunc, bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {opnd, op};
        s_tuser  <= {trunc, ls};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'(signed'($urandom_range(16)) - 8);
            3: return 64'($urandom_range(70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] rand_operator();
        logic [7:0] ops [23] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
            OP_XOR, OP_SHL, OP_SHR, OP_NEG, OP_NOT, OP_EQ, OP_NE, OP_LT, OP_LE,
            OP_GT, OP_GE, OP_LAND, OP_LOR, OP_MIN, OP_MAX, OP_ALGN};
        return ops[$urandom_range(22)];
    endfunction

    // one well-formed program with random content, maybe broken near the end
    task automatic send_program();
        int         len, d, i;
        logic [7:0] op;
        bit         broken;
        len = $urandom_range(1, 10);
        broken = ($urandom_range(9) < 2);
        d = 0;
        for (i = 0; i < len; i++) begin
            if (d < 2 || $urandom_range(2) == 0) begin
                op = ($urandom_range(3) == 0) ? OP_FLD :
                     ($urandom_range(4) == 0) ? OP_REM : OP_PUSH;
                send_item(op, rand_value(), ($urandom_range(19) == 0) ? 2'($urandom) : 2'b0,
                          $urandom_range(39) == 0, 0);
                d++;
            end else begin
                op = rand_operator();
                send_item(op, {$urandom, $urandom}, 2'($urandom), $urandom_range(1), 0);
                if (op != OP_NEG && op != OP_NOT) d--;
            end
        end
        while (d > 1) begin
            send_item(rand_operator(), '0, 2'b0, 0, 0);
            d--;
        end
        if (broken)
            send_item(8'($urandom), {$urandom, $urandom}, 2'($urandom), $urandom_range(1),
                      $urandom_range(1));
        send_item(OP_END, {$urandom, $urandom}, 2'($urandom), $urandom_range(1), 0);
        // trailing items are dropped up to last
        repeat ($urandom_range(2))
            send_item(8'($urandom), {$urandom, $urandom}, 2'($urandom), $urandom_range(1), 0);
        send_item(8'($urandom), {$urandom, $urandom}, 2'($urandom), $urandom_range(1), 1);
    endtask

    task automatic run_random(int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom), {$urandom, $urandom}, 2'($urandom),
                          $urandom_range(1), $urandom_range(3) == 0);
            else
                send_program();
        end
    endtask

    initial begin
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: overflow wrap on div, mod, then end
        send_item(OP_PUSH, 64'h8000_0000_0000_0000, 0, 0, 0);
        send_item(OP_PUSH, '1, 0, 0, 0);
        send_item(OP_DIV, '0, 0, 0, 0);
        send_item(OP_END, '0, 0, 0, 1);
        send_item(OP_PUSH, 64'h8000_0000_0000_0000, 0, 0, 0);
        send_item(OP_PUSH, '1, 0, 0, 0);
        send_item(OP_MOD, '0, 0, 0, 0);
        send_item(OP_END, '0, 0, 0, 1);
        // divide by zero, bad alignment, shift out of range
        send_item(OP_PUSH, 64'd7, 0, 0, 0);
        send_item(OP_PUSH, 64'd0, 0, 0, 0);
        send_item(OP_DIV, '0, 0, 0, 1);
        send_item(OP_PUSH, 64'd7, 0, 0, 0);
        send_item(OP_PUSH, '1, 0, 0, 0);
        send_item(OP_ALGN, '0, 0, 0, 1);
        send_item(OP_PUSH, 64'd7, 0, 0, 0);
        send_item(OP_PUSH, 64'd64, 0, 0, 0);
        send_item(OP_SHL, '0, 0, 0, 0);
        send_item(OP_END, '0, 0, 0, 1);
        // failed load, truncated push, unsupported, underflow, missing end
        send_item(OP_FLD, '1, 2'd2, 0, 1);
        send_item(OP_PUSH, '1, 0, 1, 1);
        send_item(OP_SIZE, '0, 0, 0, 1);
        send_item(OP_ADD, '0, 0, 0, 1);
        send_item(OP_REM, 64'd3, 0, 1, 1);
        // stack overflow
        for (i = 0; i <= STACK_ENTRIES; i++)
            send_item(OP_REM, 64'(i), 0, 0, i == STACK_ENTRIES);

        src_idle_pct = 10; snk_idle_pct = 66;
        run_random(530);
        src_idle_pct = 66; snk_idle_pct = 10;
        run_random(530);
        src_idle_pct = 0; snk_idle_pct = 0;
        run_random(540);
        s_tvalid <= 0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d instruction items, checked %0d results across all opcodes",
                 items_sent, sb.results);
        $display("Covered overflow, underflow, load errors and dropped trailers");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
